FILE: rtl/core/msst_pkg.sv
`timescale 1ns / 1ps

package msst_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 5;

  localparam logic [OpW-1:0] OpAdd      = 2'd0;
  localparam logic [OpW-1:0] OpRemove   = 2'd1;
  localparam logic [OpW-1:0] OpContains = 2'd2;

  typedef struct packed {
    logic            add_en;
    logic            shift_en;
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/msst_cell.sv
`timescale 1ns / 1ps

module msst_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [msst_pkg::KeyW-1:0] key_i,
  input  logic [CntW-1:0]           count_i,
  input  msst_pkg::cell_ctrl_t      ctrl_i,
  input  logic [msst_pkg::KeyW-1:0] next_i,
  input  logic                      prefix_i,
  output logic                      prefix_o,
  output logic [msst_pkg::KeyW-1:0] data_o
);

  logic [msst_pkg::KeyW-1:0] data_q;
  logic                      match_q;
  logic                      valid;

  assign valid    = count_i > CntW'(Idx);
  assign prefix_o = prefix_i | match_q;
  assign data_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (accept_i) begin
      match_q <= valid && (data_q == key_i);
    end
  end

  // shift down from the upper neighbor at and above the hit, append at the tail
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en && prefix_o) begin
      data_q <= next_i;
    end else if (ctrl_i.add_en && (count_i == CntW'(Idx))) begin
      data_q <= ctrl_i.key;
    end
  end

endmodule

FILE: rtl/core/membership_set_table.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | opcode_i, key_i
// out     | output    | out_valid_o / out_stall_i | success_o, was_present_o, full_res_o,
//         |           |                           | entry_count_o
// One request at a time: the accept edge compares the key in every cell of the chain,
// then the update edge resolves the hit through the cell chain and updates the store.
// The update waits while a held result is stalled; in_stall_o is high while busy.
// Reset clears the count and handshake state; stored keys beyond the count are unused.
// out_valid_o and the result registers are loaded at the update edge.

module membership_set_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [msst_pkg::OpW-1:0]            opcode_i,
  input  logic [msst_pkg::KeyW-1:0]           key_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                success_o,
  output logic                                was_present_o,
  output logic                                full_res_o,
  output logic [msst_pkg::CountW-1:0]         entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                          busy_q;
  logic [msst_pkg::OpW-1:0]      op_q;
  logic [msst_pkg::KeyW-1:0]     key_q;
  logic [CntW-1:0]               count_q;
  logic [CntW-1:0]               count_d;
  logic                          out_valid_q;
  logic                          success_q;
  logic                          present_q;
  logic                          full_q;
  logic [msst_pkg::CountW-1:0]   entry_q;
  logic [31:0]                   count_ext;

  logic                          accept;
  logic                          upd;
  logic                          present;
  logic                          room;
  logic                          ok;
  logic                          full;
  msst_pkg::cell_ctrl_t          ctrl;

  logic [CAPACITY:0]             prefix;
  logic [msst_pkg::KeyW-1:0]     data [CAPACITY];

  assign accept  = in_valid_i && !in_stall_o;
  assign upd     = busy_q && (!out_valid_q || !out_stall_i);
  assign present = prefix[CAPACITY];
  assign room    = count_q < CntW'(CAPACITY);

  assign prefix[0] = 1'b0;

  assign ctrl.add_en   = upd && (op_q == msst_pkg::OpAdd) && !present && room;
  assign ctrl.shift_en = upd && (op_q == msst_pkg::OpRemove) && present;
  assign ctrl.key      = key_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [msst_pkg::KeyW-1:0] next;
    if (i == CAPACITY - 1) begin : g_last
      assign next = data[i];
    end else begin : g_mid
      assign next = data[i+1];
    end
    msst_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .key_i    (key_i),
      .count_i  (count_q),
      .ctrl_i   (ctrl),
      .next_i   (next),
      .prefix_i (prefix[i]),
      .prefix_o (prefix[i+1]),
      .data_o   (data[i])
    );
  end

  always_comb begin
    count_d = count_q;
    ok      = 1'b0;
    full    = 1'b0;
    unique case (op_q)
      msst_pkg::OpAdd: begin
        ok   = present || room;
        full = !present && !room;
        if (ctrl.add_en) begin
          count_d = count_q + CntW'(1);
        end
      end
      msst_pkg::OpRemove: begin
        ok = 1'b1;
        if (ctrl.shift_en) begin
          count_d = count_q - CntW'(1);
        end
      end
      msst_pkg::OpContains: begin
        ok = present;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (upd) begin
        busy_q <= 1'b0;
      end
      if (upd) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
    end
    if (upd) begin
      success_q <= ok;
      present_q <= present;
      full_q    <= full;
      entry_q   <= count_ext[msst_pkg::CountW-1:0];
    end
  end

  assign in_stall_o    = busy_q;
  assign out_valid_o   = out_valid_q;
  assign success_o     = success_q;
  assign was_present_o = present_q;
  assign full_res_o    = full_q;
  assign entry_count_o = entry_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("key count above capacity");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(count_q))
    else $error("key count changed outside an update");

  a_full_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_res_o) |-> (!success_o && !was_present_o))
    else $error("refused add reported success");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && !out_valid_q) || (busy_q && out_valid_q))
    else $error("request not held after accept");

endmodule
